### sv/cflm_pkg.sv
// Shared types and codes for the CAN frame length monitor.
// Used by the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cflm_pkg;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // Stored verdict codes
  localparam logic [1:0] VERDICT_INITIAL = 2'd0;
  localparam logic [1:0] VERDICT_EQUAL   = 2'd1;
  localparam logic [1:0] VERDICT_LONG    = 2'd2;
  localparam logic [1:0] VERDICT_SHORT   = 2'd3;

  // Reported event kinds
  localparam logic [1:0] KIND_EQUAL = 2'd0;
  localparam logic [1:0] KIND_LONG  = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [7:0]  net;
    logic [28:0] can;
    logic [6:0]  expected;
    logic [1:0]  verdict;
  } entry_t;

endpackage

`default_nettype wire

### sv/cflm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cflm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/can_frame_length_monitor.sv
// CAN frame length monitor top level: entry table scan and verdict update.
// Depends on cflm_pkg and cflm_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Items enter on start while busy is low. A load item (in_func = 0) writes
//   one table entry (network, identifier, expected length) and sets its
//   verdict to initial; its result strobes in the next cycle and busy stays low.
//   A check item (in_func = 1) scans entries 0 .. min(entry_count,
//   TABLE_DEPTH)-1 through the single read port of the entry memory, one
//   entry per cycle, and stops at the lowest match. The result strobes in the
//   first cycle in which busy is low again. Each result is marked by
//   out_strobe, high for a single cycle, and held on the out_ ports until the
//   next one; the receiver cannot stall. A verdict change writes back the
//   entry in the cycle the match is seen, and the next item is only taken
//   after that, so accesses to one entry never overlap.
//   entry_count is written through cfg_wr_en/cfg_wr_data; the user must do so
//   only while idle, as the block does not enforce it.
//   Reset (rst_n low, synchronous) clears entry_count and the sequencer. The
//   table itself is not cleared: only loaded entries are meaningful.
module can_frame_length_monitor #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // input items
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [5:0]  in_slot,
  input  logic [7:0]  in_net_id,
  input  logic [28:0] in_can_id,
  input  logic [6:0]  in_frame_length,
  input  logic [31:0] in_timestamp,
  // results
  output logic        out_strobe,
  output logic        out_frame_ok,
  output logic        out_event_valid,
  output logic [1:0]  out_event_kind,
  output logic [7:0]  out_event_net,
  output logic [28:0] out_event_can,
  output logic [6:0]  out_seen_length,
  output logic [6:0]  out_expected_length,
  output logic [31:0] out_event_time
);

  import cflm_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int IW = AW + 1;
  localparam int EW = $bits(entry_t);

  // Registers
  state_t      state_r, state_nxt;
  logic [6:0]  entry_count_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic [IW-1:0] limit_r, limit_nxt;
  logic [7:0]  net_r, net_nxt;
  logic [28:0] can_r, can_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [31:0] ts_r, ts_nxt;

  logic        out_strobe_r, out_strobe_nxt;
  logic        frame_ok_r, frame_ok_nxt;
  logic        event_valid_r, event_valid_nxt;
  logic [1:0]  event_kind_r, event_kind_nxt;
  logic [7:0]  event_net_r, event_net_nxt;
  logic [28:0] event_can_r, event_can_nxt;
  logic [6:0]  seen_len_r, seen_len_nxt;
  logic [6:0]  exp_len_r, exp_len_nxt;
  logic [31:0] event_time_r, event_time_nxt;

  // Memory port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wentry;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_ent;

  // Control terms
  logic       accept;
  logic       load_acc;
  logic       check_acc;
  logic       slot_ok;
  logic       hit;
  logic       no_match;
  logic       finish;
  logic       issue;
  logic       longer;
  logic       shorter;
  logic [1:0] new_verdict;
  logic [1:0] new_kind;
  logic       changed;

  cflm_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign busy      = (state_r == ST_SCAN);
  assign accept    = start && !busy;
  assign load_acc  = accept && (in_func == FUNC_LOAD);
  assign check_acc = accept && (in_func == FUNC_CHECK);
  assign slot_ok   = (32'(in_slot) < 32'(TABLE_DEPTH));

  // Match evaluation on the entry returned by the read port
  assign hit      = (state_r == ST_SCAN) && rd_pend_r &&
                    (rd_ent.net == net_r) && (rd_ent.can == can_r);
  assign no_match = (state_r == ST_SCAN) && !hit && (idx_r >= limit_r);
  assign finish   = hit || no_match;
  assign issue    = (state_r == ST_SCAN) && !finish && (idx_r < limit_r);
  assign longer   = (len_r > rd_ent.expected);
  assign shorter  = (len_r < rd_ent.expected);

  always_comb begin
    if (longer) begin
      new_verdict = VERDICT_LONG;
      new_kind    = KIND_LONG;
    end else if (shorter) begin
      new_verdict = VERDICT_SHORT;
      new_kind    = KIND_SHORT;
    end else begin
      new_verdict = VERDICT_EQUAL;
      new_kind    = KIND_EQUAL;
    end
  end

  assign changed = (rd_ent.verdict != new_verdict);

  // Memory write: load in idle, verdict write-back on a changed hit
  always_comb begin
    ram_raddr = idx_r[AW-1:0];
    if (load_acc) begin
      ram_we             = slot_ok;
      ram_waddr          = AW'(in_slot);
      ram_wentry.net     = in_net_id;
      ram_wentry.can     = in_can_id;
      ram_wentry.expected = in_frame_length;
      ram_wentry.verdict = VERDICT_INITIAL;
    end else begin
      ram_we             = hit && changed;
      ram_waddr          = rd_idx_r[AW-1:0];
      ram_wentry         = rd_ent;
      ram_wentry.verdict = new_verdict;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (check_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Scan counters, item capture and result assembly
  always_comb begin
    idx_nxt     = idx_r;
    rd_idx_nxt  = rd_idx_r;
    rd_pend_nxt = 1'b0;
    limit_nxt   = limit_r;
    net_nxt     = net_r;
    can_nxt     = can_r;
    len_nxt     = len_r;
    ts_nxt      = ts_r;

    out_strobe_nxt  = 1'b0;
    frame_ok_nxt    = frame_ok_r;
    event_valid_nxt = event_valid_r;
    event_kind_nxt  = event_kind_r;
    event_net_nxt   = event_net_r;
    event_can_nxt   = event_can_r;
    seen_len_nxt    = seen_len_r;
    exp_len_nxt     = exp_len_r;
    event_time_nxt  = event_time_r;

    // capture a check item
    if (check_acc) begin
      idx_nxt   = '0;
      net_nxt   = in_net_id;
      can_nxt   = in_can_id;
      len_nxt   = in_frame_length;
      ts_nxt    = in_timestamp;
      limit_nxt = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ?
                  IW'(TABLE_DEPTH) : IW'(entry_count_r);
    end

    // issue the next read
    if (issue) begin
      idx_nxt     = idx_r + IW'(1);
      rd_idx_nxt  = idx_r;
      rd_pend_nxt = 1'b1;
    end

    // result of a load, an unmatched check or a matched check
    if (load_acc || no_match || hit) begin
      out_strobe_nxt  = 1'b1;
      frame_ok_nxt    = 1'b1;
      event_valid_nxt = 1'b0;
      event_kind_nxt  = KIND_EQUAL;
      event_net_nxt   = '0;
      event_can_nxt   = '0;
      seen_len_nxt    = '0;
      exp_len_nxt     = '0;
      event_time_nxt  = '0;
      if (hit) begin
        frame_ok_nxt = !(longer || shorter);
        if (changed) begin
          event_valid_nxt = 1'b1;
          event_kind_nxt  = new_kind;
          event_net_nxt   = net_r;
          event_can_nxt   = can_r;
          seen_len_nxt    = len_r;
          exp_len_nxt     = rd_ent.expected;
          event_time_nxt  = ts_r;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rd_pend_r     <= 1'b0;
      out_strobe_r  <= 1'b0;
      entry_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_wr_en) begin
        entry_count_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r         <= idx_nxt;
    rd_idx_r      <= rd_idx_nxt;
    limit_r       <= limit_nxt;
    net_r         <= net_nxt;
    can_r         <= can_nxt;
    len_r         <= len_nxt;
    ts_r          <= ts_nxt;
    frame_ok_r    <= frame_ok_nxt;
    event_valid_r <= event_valid_nxt;
    event_kind_r  <= event_kind_nxt;
    event_net_r   <= event_net_nxt;
    event_can_r   <= event_can_nxt;
    seen_len_r    <= seen_len_nxt;
    exp_len_r     <= exp_len_nxt;
    event_time_r  <= event_time_nxt;
  end

  assign out_strobe          = out_strobe_r;
  assign out_frame_ok        = frame_ok_r;
  assign out_event_valid     = event_valid_r;
  assign out_event_kind      = event_kind_r;
  assign out_event_net       = event_net_r;
  assign out_event_can       = event_can_r;
  assign out_seen_length     = seen_len_r;
  assign out_expected_length = exp_len_r;
  assign out_event_time      = event_time_r;

  // A pending read only exists inside a scan and is within the limit
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SCAN) && (rd_idx_r < limit_r))
    else $error("pending table read outside an active scan");

  // A check item produces no result in the cycle right after it is taken
  a_check_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    check_acc |=> !out_strobe)
    else $error("check result strobed too early");

  // Pass or fail agrees with the reported kind
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_event_valid) |-> (out_frame_ok == (out_event_kind == KIND_EQUAL)))
    else $error("frame_ok disagrees with event kind");

  // Leaving a scan always yields exactly one result next cycle
  a_scan_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && finish |=> out_strobe && (state_r == ST_IDLE))
    else $error("scan ended without a result");

  // No verdict write-back while a load is being written
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> !load_acc)
    else $error("write port conflict");

endmodule

`default_nettype wire
